// File: design/ugbnq_pkg.sv
package ugbnq_pkg;

	localparam int MAX_PARTICLES = 4096;
	localparam int MAX_CELLS     = 1024;
	localparam int MAX_GRID_SIDE = 32;
	localparam int MAX_NEIGHBORS = 64;

	localparam int ID_W   = 12;
	localparam int CNT_W  = 13;
	localparam int CELL_W = 10;
	localparam int OFS_AW = 11;
	localparam int NB_AW  = 6;
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [1:0] FN_LOAD  = 2'd0;
	localparam logic [1:0] FN_BUILD = 2'd1;
	localparam logic [1:0] FN_QUERY = 2'd2;
	localparam logic [1:0] FN_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_NOID   = 2'd2;
	localparam logic [1:0] ST_NOGRID = 2'd3;

	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_INV_CELL = 3'd2;
	localparam logic [2:0] CFG_COLS     = 3'd3;
	localparam logic [2:0] CFG_ROWS     = 3'd4;
	localparam logic [2:0] CFG_EXCL     = 3'd5;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [11:0]        particle_id;
	} cmd_t;

	typedef struct packed {
		logic [11:0] item_id;
		logic        has_id;
		logic        last;
		logic        truncated;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic signed [23:0] origin_x;
		logic signed [23:0] origin_y;
		logic [23:0]        inv_cell_size;
		logic [5:0]         grid_columns;
		logic [5:0]         grid_rows;
		logic               exclude_self;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [5:0]  cy;
		logic [5:0]  cx;
		logic [11:0] pid;
	} qent_t;

endpackage

// File: design/ugbnq_cmdq.sv
module ugbnq_cmdq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ugbnq_pkg::qent_t  din,
	output logic              full,
	input  logic              pop,
	output ugbnq_pkg::qent_t  dout,
	output logic              empty
);

	ugbnq_pkg::qent_t mem_q [ugbnq_pkg::QDEPTH];
	logic [ugbnq_pkg::QAW:0] wp_q, rp_q;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[ugbnq_pkg::QAW] != rp_q[ugbnq_pkg::QAW]) &&
		(wp_q[ugbnq_pkg::QAW-1:0] == rp_q[ugbnq_pkg::QAW-1:0]);
	assign dout  = mem_q[rp_q[ugbnq_pkg::QAW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q[ugbnq_pkg::QAW-1:0]] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
		end
	end

endmodule

// File: design/ugbnq_front.sv
module ugbnq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  ugbnq_pkg::cfg_t   cfg,
	input  logic              push,
	output logic              full,
	input  ugbnq_pkg::cmd_t   cmd,
	output logic              q_push,
	output ugbnq_pkg::qent_t  q_din,
	input  logic              q_full
);

	logic               v_s1, v_s2;
	logic [1:0]         func_s1, func_s2;
	logic [11:0]        pid_s1, pid_s2;
	logic signed [24:0] dx_s1, dy_s1;
	logic signed [49:0] px_s2, py_s2;
	logic signed [25:0] qx, qy;
	logic               en;

	assign en     = !(v_s2 && q_full);
	assign full   = !en;
	assign q_push = v_s2 && !q_full;

	assign qx = px_s2[49:24];
	assign qy = py_s2[49:24];

	always_comb begin
		q_din.func = func_s2;
		q_din.pid  = pid_s2;
		if (qx < -26'sd2) begin
			q_din.cx = 6'd0;
		end else if (qx > 26'(ugbnq_pkg::MAX_GRID_SIDE + 1)) begin
			q_din.cx = 6'(ugbnq_pkg::MAX_GRID_SIDE + 3);
		end else begin
			q_din.cx = 6'(qx + 26'sd2);
		end
		if (qy < -26'sd2) begin
			q_din.cy = 6'd0;
		end else if (qy > 26'(ugbnq_pkg::MAX_GRID_SIDE + 1)) begin
			q_din.cy = 6'(ugbnq_pkg::MAX_GRID_SIDE + 3);
		end else begin
			q_din.cy = 6'(qy + 26'sd2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= cmd.func;
			pid_s1  <= cmd.particle_id;
			dx_s1   <= {cmd.pos_x[23], cmd.pos_x} - {cfg.origin_x[23], cfg.origin_x};
			dy_s1   <= {cmd.pos_y[23], cmd.pos_y} - {cfg.origin_y[23], cfg.origin_y};
			func_s2 <= func_s1;
			pid_s2  <= pid_s1;
			px_s2   <= dx_s1 * $signed({1'b0, cfg.inv_cell_size});
			py_s2   <= dy_s1 * $signed({1'b0, cfg.inv_cell_size});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

endmodule

// File: design/ugbnq_back.sv
module ugbnq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ugbnq_pkg::cfg_t   cfg,
	input  logic              geo_wr,
	input  logic              q_empty,
	output logic              q_pop,
	input  ugbnq_pkg::qent_t  q_dout,
	output ugbnq_pkg::res_t   res,
	output logic              empty,
	input  logic              pop
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RES   = 5'd1;
	localparam logic [4:0] S_BZERO = 5'd2;
	localparam logic [4:0] S_HRD   = 5'd3;
	localparam logic [4:0] S_HBIN  = 5'd4;
	localparam logic [4:0] S_HWR   = 5'd5;
	localparam logic [4:0] S_P0    = 5'd6;
	localparam logic [4:0] S_PRD   = 5'd7;
	localparam logic [4:0] S_PWR   = 5'd8;
	localparam logic [4:0] S_SRD   = 5'd9;
	localparam logic [4:0] S_SBIN  = 5'd10;
	localparam logic [4:0] S_SWR   = 5'd11;
	localparam logic [4:0] S_QCELL = 5'd12;
	localparam logic [4:0] S_QNB   = 5'd13;
	localparam logic [4:0] S_QLO   = 5'd14;
	localparam logic [4:0] S_QHI   = 5'd15;
	localparam logic [4:0] S_QSRD  = 5'd16;
	localparam logic [4:0] S_QSID  = 5'd17;
	localparam logic [4:0] S_QEND  = 5'd18;
	localparam logic [4:0] S_ERD   = 5'd19;
	localparam logic [4:0] S_EWR   = 5'd20;

	logic [4:0]  st_q;
	logic [12:0] cnt_q, acc_q, j_q, hi_q;
	logic        built_q, trunc_q, rv_q;
	logic [9:0]  c_q, bin_q, cell_q;
	logic [11:0] i_q, pid_q;
	logic [5:0]  qx_q, qy_q, k_q;
	logic [1:0]  dxi_q, dyi_q;
	logic [6:0]  n_q;
	ugbnq_pkg::res_t pend_q, res_q;

	logic [11:0] pcell_q [ugbnq_pkg::MAX_PARTICLES];
	logic [12:0] counts_q [ugbnq_pkg::MAX_CELLS];
	logic [12:0] offs_q [ugbnq_pkg::MAX_CELLS + 1];
	logic [11:0] sorted_q [ugbnq_pkg::MAX_PARTICLES];
	logic [11:0] nbuf_q [ugbnq_pkg::MAX_NEIGHBORS];
	logic [11:0] pdat_q, sdat_q, bdat_q;
	logic [12:0] cdat_q, odat_q;

	logic        p_re, p_we, c_re, c_we, o_re, o_we, s_re, s_we, b_re, b_we;
	logic [11:0] p_ra, p_wa, p_wd, s_ra, s_wa, s_wd, b_wd;
	logic [9:0]  c_ra, c_wa;
	logic [12:0] c_wd, o_wd;
	logic [10:0] o_ra, o_wa;
	logic [5:0]  b_ra, b_wa;

	logic [5:0]  cols, rows, xr, yr, cxc, cyc;
	logic [11:0] ncell, bin_w, cell_w;
	logic        last_cell, room, keep, nb_last, inb, last_i;
	logic        emit, build_done, unbuild;
	logic signed [7:0] nx, ny;

	function automatic ugbnq_pkg::res_t mk(input logic [11:0] id, input logic has,
		input logic lst, input logic tr, input logic [1:0] stat);
		ugbnq_pkg::res_t r;
		r.item_id   = id;
		r.has_id    = has;
		r.last      = lst;
		r.truncated = tr;
		r.status    = stat;
		return r;
	endfunction

	always_comb begin
		if (cfg.grid_columns == 6'd0) begin
			cols = 6'd1;
		end else if (cfg.grid_columns > 6'(ugbnq_pkg::MAX_GRID_SIDE)) begin
			cols = 6'(ugbnq_pkg::MAX_GRID_SIDE);
		end else begin
			cols = cfg.grid_columns;
		end
		if (cfg.grid_rows == 6'd0) begin
			rows = 6'd1;
		end else if (cfg.grid_rows > 6'(ugbnq_pkg::MAX_GRID_SIDE)) begin
			rows = 6'(ugbnq_pkg::MAX_GRID_SIDE);
		end else begin
			rows = cfg.grid_rows;
		end
	end

	assign ncell     = {6'd0, cols} * {6'd0, rows};
	assign last_cell = ({2'b00, c_q} == ncell - 12'd1);
	assign last_i    = ({1'b0, i_q} == cnt_q - 13'd1);
	assign room      = !rv_q || pop;

	assign xr  = pdat_q[5:0];
	assign yr  = pdat_q[11:6];
	assign cxc = (xr < 6'd2) ? 6'd0 : ((xr - 6'd2 > cols - 6'd1) ? cols - 6'd1 : xr - 6'd2);
	assign cyc = (yr < 6'd2) ? 6'd0 : ((yr - 6'd2 > rows - 6'd1) ? rows - 6'd1 : yr - 6'd2);
	assign bin_w = {6'd0, cyc} * {6'd0, cols} + {6'd0, cxc};

	assign nx  = $signed({2'b00, qx_q}) + $signed({6'd0, dxi_q}) - 8'sd3;
	assign ny  = $signed({2'b00, qy_q}) + $signed({6'd0, dyi_q}) - 8'sd3;
	assign inb = (nx >= 8'sd0) && (nx < $signed({2'b00, cols})) &&
		(ny >= 8'sd0) && (ny < $signed({2'b00, rows}));
	assign cell_w  = {6'd0, ny[5:0]} * {6'd0, cols} + {6'd0, nx[5:0]};
	assign nb_last = (dxi_q == 2'd2) && (dyi_q == 2'd2);
	assign keep    = !(cfg.exclude_self && (sdat_q == pid_q));

	assign q_pop = (st_q == S_IDLE) && !q_empty;
	assign res   = res_q;
	assign empty = !rv_q;

	assign emit       = room && ((st_q == S_RES) || (st_q == S_EWR));
	assign build_done = ((st_q == S_PWR) && last_cell && (cnt_q == '0)) ||
		((st_q == S_SWR) && last_i);
	assign unbuild    = geo_wr || (q_pop &&
		(((q_dout.func == ugbnq_pkg::FN_LOAD) && !cnt_q[12]) ||
		(q_dout.func == ugbnq_pkg::FN_CLEAR)));

	always_comb begin
		p_re = 1'b0; p_ra = i_q; p_we = 1'b0; p_wa = cnt_q[11:0];
		p_wd = {q_dout.cy, q_dout.cx};
		c_re = 1'b0; c_ra = bin_w[9:0]; c_we = 1'b0; c_wa = bin_q; c_wd = cdat_q + 13'd1;
		o_re = 1'b0; o_ra = {1'b0, bin_w[9:0]}; o_we = 1'b0;
		o_wa = 11'({1'b0, c_q} + 11'd1); o_wd = acc_q + cdat_q;
		s_re = 1'b0; s_ra = j_q[11:0]; s_we = 1'b0; s_wa = 12'(odat_q + cdat_q); s_wd = i_q;
		b_re = 1'b0; b_ra = k_q; b_we = 1'b0; b_wa = n_q[5:0]; b_wd = sdat_q;
		case (st_q)
			S_IDLE: begin
				p_re = 1'b1;
				p_ra = q_dout.pid;
				p_we = q_pop && (q_dout.func == ugbnq_pkg::FN_LOAD) && !cnt_q[12];
			end
			S_BZERO: begin
				c_we = 1'b1; c_wa = c_q; c_wd = '0;
			end
			S_HRD, S_SRD: p_re = 1'b1;
			S_HBIN: c_re = 1'b1;
			S_HWR: c_we = 1'b1;
			S_P0: begin
				o_we = 1'b1; o_wa = '0; o_wd = '0;
			end
			S_PRD: begin
				c_re = 1'b1; c_ra = c_q;
			end
			S_PWR: begin
				o_we = 1'b1;
				c_we = 1'b1; c_wa = c_q; c_wd = '0;
			end
			S_SBIN: begin
				c_re = 1'b1; o_re = 1'b1;
			end
			S_SWR: begin
				c_we = 1'b1; s_we = 1'b1;
			end
			S_QNB: begin
				o_re = inb; o_ra = {1'b0, cell_w[9:0]};
			end
			S_QLO: begin
				o_re = 1'b1; o_ra = 11'({1'b0, cell_q} + 11'd1);
			end
			S_QSRD: s_re = (j_q < hi_q);
			S_QSID: b_we = keep && (n_q < 7'(ugbnq_pkg::MAX_NEIGHBORS));
			S_ERD: b_re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we) pcell_q[p_wa] <= p_wd;
		if (p_re) pdat_q <= pcell_q[p_ra];
		if (c_we) counts_q[c_wa] <= c_wd;
		if (c_re) cdat_q <= counts_q[c_ra];
		if (o_we) offs_q[o_wa] <= o_wd;
		if (o_re) odat_q <= offs_q[o_ra];
		if (s_we) sorted_q[s_wa] <= s_wd;
		if (s_re) sdat_q <= sorted_q[s_ra];
		if (b_we) nbuf_q[b_wa] <= b_wd;
		if (b_re) bdat_q <= nbuf_q[b_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (emit) begin
			rv_q <= 1'b1;
		end else if (pop) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q <= 1'b0;
		end else if (unbuild) begin
			built_q <= 1'b0;
		end else if (build_done) begin
			built_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			cnt_q   <= '0;
			res_q   <= '0;
			pend_q  <= '0;
			acc_q   <= '0;
			j_q     <= '0;
			hi_q    <= '0;
			trunc_q <= 1'b0;
			c_q     <= '0;
			bin_q   <= '0;
			cell_q  <= '0;
			i_q     <= '0;
			pid_q   <= '0;
			qx_q    <= '0;
			qy_q    <= '0;
			k_q     <= '0;
			dxi_q   <= '0;
			dyi_q   <= '0;
			n_q     <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_dout.func)
							ugbnq_pkg::FN_LOAD: begin
								if (cnt_q[12]) begin
									pend_q <= mk('0, 1'b0, 1'b1, 1'b0, ugbnq_pkg::ST_FULL);
								end else begin
									pend_q <= mk(cnt_q[11:0], 1'b1, 1'b1, 1'b0, ugbnq_pkg::ST_OK);
									cnt_q  <= cnt_q + 13'd1;
								end
								st_q <= S_RES;
							end
							ugbnq_pkg::FN_BUILD: begin
								c_q  <= '0;
								st_q <= S_BZERO;
							end
							ugbnq_pkg::FN_QUERY: begin
								pid_q <= q_dout.pid;
								if (!built_q) begin
									pend_q <= mk('0, 1'b0, 1'b1, 1'b0, ugbnq_pkg::ST_NOGRID);
									st_q   <= S_RES;
								end else if ({1'b0, q_dout.pid} >= cnt_q) begin
									pend_q <= mk('0, 1'b0, 1'b1, 1'b0, ugbnq_pkg::ST_NOID);
									st_q   <= S_RES;
								end else begin
									st_q <= S_QCELL;
								end
							end
							default: begin
								cnt_q  <= '0;
								pend_q <= mk('0, 1'b0, 1'b1, 1'b0, ugbnq_pkg::ST_OK);
								st_q   <= S_RES;
							end
						endcase
					end
				end
				S_RES: begin
					if (room) begin
						res_q <= pend_q;
						st_q  <= S_IDLE;
					end
				end
				S_BZERO: begin
					if (last_cell) begin
						i_q  <= '0;
						st_q <= (cnt_q == '0) ? S_P0 : S_HRD;
					end else begin
						c_q <= c_q + 10'd1;
					end
				end
				S_HRD: st_q <= S_HBIN;
				S_HBIN: begin
					bin_q <= bin_w[9:0];
					st_q  <= S_HWR;
				end
				S_HWR: begin
					if (last_i) begin
						st_q <= S_P0;
					end else begin
						i_q  <= i_q + 12'd1;
						st_q <= S_HRD;
					end
				end
				S_P0: begin
					acc_q <= '0;
					c_q   <= '0;
					st_q  <= S_PRD;
				end
				S_PRD: st_q <= S_PWR;
				S_PWR: begin
					acc_q <= acc_q + cdat_q;
					if (last_cell) begin
						i_q <= '0;
						if (cnt_q == '0) begin
							pend_q <= mk('0, 1'b0, 1'b1, 1'b0, ugbnq_pkg::ST_OK);
							st_q   <= S_RES;
						end else begin
							st_q <= S_SRD;
						end
					end else begin
						c_q  <= c_q + 10'd1;
						st_q <= S_PRD;
					end
				end
				S_SRD: st_q <= S_SBIN;
				S_SBIN: begin
					bin_q <= bin_w[9:0];
					st_q  <= S_SWR;
				end
				S_SWR: begin
					if (last_i) begin
						pend_q <= mk('0, 1'b0, 1'b1, 1'b0, ugbnq_pkg::ST_OK);
						st_q   <= S_RES;
					end else begin
						i_q  <= i_q + 12'd1;
						st_q <= S_SRD;
					end
				end
				S_QCELL: begin
					qx_q    <= pdat_q[5:0];
					qy_q    <= pdat_q[11:6];
					dxi_q   <= '0;
					dyi_q   <= '0;
					n_q     <= '0;
					trunc_q <= 1'b0;
					st_q    <= S_QNB;
				end
				S_QNB: begin
					if (inb) begin
						cell_q <= cell_w[9:0];
						st_q   <= S_QLO;
					end else if (nb_last) begin
						st_q <= S_QEND;
					end else if (dxi_q == 2'd2) begin
						dxi_q <= '0;
						dyi_q <= dyi_q + 2'd1;
					end else begin
						dxi_q <= dxi_q + 2'd1;
					end
				end
				S_QLO: begin
					j_q  <= odat_q;
					st_q <= S_QHI;
				end
				S_QHI: begin
					hi_q <= odat_q;
					st_q <= S_QSRD;
				end
				S_QSRD: begin
					if (j_q < hi_q) begin
						st_q <= S_QSID;
					end else if (nb_last) begin
						st_q <= S_QEND;
					end else begin
						if (dxi_q == 2'd2) begin
							dxi_q <= '0;
							dyi_q <= dyi_q + 2'd1;
						end else begin
							dxi_q <= dxi_q + 2'd1;
						end
						st_q <= S_QNB;
					end
				end
				S_QSID: begin
					if (keep) begin
						if (n_q < 7'(ugbnq_pkg::MAX_NEIGHBORS)) begin
							n_q <= n_q + 7'd1;
						end else begin
							trunc_q <= 1'b1;
						end
					end
					j_q  <= j_q + 13'd1;
					st_q <= S_QSRD;
				end
				S_QEND: begin
					k_q <= '0;
					if (n_q == '0) begin
						pend_q <= mk('0, 1'b0, 1'b1, 1'b0, ugbnq_pkg::ST_OK);
						st_q   <= S_RES;
					end else begin
						st_q <= S_ERD;
					end
				end
				S_ERD: st_q <= S_EWR;
				S_EWR: begin
					if (room) begin
						res_q <= mk(bdat_q, 1'b1, {1'b0, k_q} == n_q - 7'd1, trunc_q,
							ugbnq_pkg::ST_OK);
						if ({1'b0, k_q} == n_q - 7'd1) begin
							st_q <= S_IDLE;
						end else begin
							k_q  <= k_q + 6'd1;
							st_q <= S_ERD;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_nb_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 7'(ugbnq_pkg::MAX_NEIGHBORS))
		else $error("neighbour count past limit");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 13'(ugbnq_pkg::MAX_PARTICLES))
		else $error("particle count past store size");

	a_load_unbuilds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_dout.func == ugbnq_pkg::FN_LOAD && !cnt_q[12]) |=> !built_q)
		else $error("grid still marked built after load");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EWR) |-> (n_q != '0))
		else $error("emitting from empty neighbour list");

	a_trunc_full: assert property (@(posedge clk) disable iff (!arst_n)
		trunc_q && (st_q == S_EWR) |-> (n_q == 7'(ugbnq_pkg::MAX_NEIGHBORS)))
		else $error("truncation without full list");

endmodule

// File: design/uniform_grid_bin_and_neighbor_query_top.sv
// channel  | handshake        | payload
// cmd      | push / full      | cmd_t: func, pos_x, pos_y, particle_id
// res      | pop / empty      | res_t: item_id, has_id, last, truncated, status
// cfg      | cfg_we           | cfg_index, cfg_wdata
// Load: 2 front stages, then back states IDLE and RES; a new load is taken only once RES has handed its result on.
// Build: zero the cell counts, histogram particles per cell, form prefix offsets, then scatter ids.
// Query: scan the 3x3 cells around the particle's cell, then emit each id kept,
// one result per id.
// Front and back stall independently through a 4-beat command queue.
// Reset clears counters and flags; the memories are written before read.
module uniform_grid_bin_and_neighbor_query_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  ugbnq_pkg::cmd_t  cmd,
	output logic             empty,
	input  logic             pop,
	output ugbnq_pkg::res_t  res,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [23:0]      cfg_wdata
);

	ugbnq_pkg::cfg_t   cfg_q;
	ugbnq_pkg::qent_t  q_din, q_dout;
	logic              q_push, q_full, q_pop, q_empty, geo_wr;

	assign geo_wr = cfg_we &&
		((cfg_index == ugbnq_pkg::CFG_COLS) || (cfg_index == ugbnq_pkg::CFG_ROWS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.inv_cell_size <= 24'd65536;
			cfg_q.grid_columns  <= 6'(ugbnq_pkg::MAX_GRID_SIDE);
			cfg_q.grid_rows     <= 6'(ugbnq_pkg::MAX_GRID_SIDE);
			cfg_q.exclude_self  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				ugbnq_pkg::CFG_ORIGIN_X: cfg_q.origin_x      <= $signed(cfg_wdata);
				ugbnq_pkg::CFG_ORIGIN_Y: cfg_q.origin_y      <= $signed(cfg_wdata);
				ugbnq_pkg::CFG_INV_CELL: cfg_q.inv_cell_size <= cfg_wdata;
				ugbnq_pkg::CFG_COLS:     cfg_q.grid_columns  <= cfg_wdata[5:0];
				ugbnq_pkg::CFG_ROWS:     cfg_q.grid_rows     <= cfg_wdata[5:0];
				ugbnq_pkg::CFG_EXCL:     cfg_q.exclude_self  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	ugbnq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.full   (full),
		.cmd    (cmd),
		.q_push (q_push),
		.q_din  (q_din),
		.q_full (q_full)
	);

	ugbnq_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	ugbnq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.geo_wr  (geo_wr),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_dout  (q_dout),
		.res     (res),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
